/* rtl/bal_pkg.sv */
// Shared types and codes of the bump arena allocator.
// Holds the request, result and internal command formats; no dependencies.
package bal_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP  = 1'b1;

  // Request type codes.
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_REWIND = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOMEM    = 3'd3;
  localparam logic [2:0] ST_INTERNAL = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_CLEAR,
    OP_REWIND,
    OP_BAD
  } op_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] alloc_size;
    logic [DATA_W-1:0] alignment;
    logic [DATA_W-1:0] mark_offset;
    logic [DATA_W-1:0] mark_generation;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] alloc_address;
    logic [DATA_W-1:0] used;
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] peak_used;
    logic [DATA_W-1:0] epoch;
  } res_t;

  // Classified command. For an allocate, arg_a is the size and arg_b the
  // alignment mask; for a rewind, arg_a is the mark offset and arg_b the
  // mark generation.
  typedef struct packed {
    op_e               op;
    logic              bad_arg;
    logic              align_wide;
    logic [DATA_W-1:0] arg_a;
    logic [DATA_W-1:0] arg_b;
  } cmd_t;

endpackage

/* rtl/bal_stream_if.sv */
// Valid/ready channel carrying one item of type T.
// Used for the request and result channels; no dependencies.
interface bal_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/bal_fifo.sv */
// Small first-in first-out queue between the front and back parts.
// Generic over the entry type; no package dependencies.
module bal_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/bal_front.sv */
// Front part: accepts requests and classifies them into commands.
// Depends on bal_pkg and bal_stream_if.
module bal_front import bal_pkg::*; #(
  parameter int ADDR_W = 32
) (
  bal_stream_if.sink req_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  // Alignments at or above this bit position exceed the address space.
  localparam int ALIGN_CLIP = (ADDR_W < DATA_W) ? ADDR_W : DATA_W;

  logic [DATA_W-1:0] align_mask;

  assign req_i.ready = !q_full_i;
  assign push_o      = req_i.valid && !q_full_i;
  assign align_mask  = req_i.data.alignment - 1'b1;

  always_comb begin
    cmd_o.bad_arg    = (req_i.data.alloc_size == '0) || (req_i.data.alignment == '0) ||
                       ((req_i.data.alignment & align_mask) != '0);
    cmd_o.align_wide = ((req_i.data.alignment >> ALIGN_CLIP) != '0);
    cmd_o.arg_a      = req_i.data.alloc_size;
    cmd_o.arg_b      = align_mask;
    case (req_i.data.req_type)
      REQ_ALLOC: begin
        cmd_o.op = OP_ALLOC;
      end
      REQ_CLEAR: begin
        cmd_o.op = OP_CLEAR;
      end
      REQ_REWIND: begin
        cmd_o.op    = OP_REWIND;
        cmd_o.arg_a = req_i.data.mark_offset;
        cmd_o.arg_b = req_i.data.mark_generation;
      end
      default: begin
        cmd_o.op = OP_BAD;
      end
    endcase
  end

endmodule

/* rtl/bal_back.sv */
// Back part: owns the cursor, peak and generation and executes commands.
// Depends on bal_pkg and bal_stream_if; results leave through an output register.
module bal_back import bal_pkg::*; #(
  parameter int ADDR_W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [DATA_W-1:0]    base_i,
  input  logic [DATA_W-1:0]    cap_i,
  input  logic                 q_empty_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  bal_stream_if.source         res_o
);

  // Absolute addresses at or above this bit position exceed the address space.
  localparam int ADDR_CLIP = (ADDR_W < DATA_W + 1) ? ADDR_W : DATA_W + 1;

  logic [DATA_W-1:0] cursor_q, cursor_d, peak_q, peak_d, gen_q, gen_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q, status_d;
  logic [DATA_W-1:0] addr_q, addr_d;
  logic [DATA_W-1:0] used_q, peak_out_q, epoch_q;

  logic [DATA_W:0]   cur_addr, total, with_pad, final_off;
  logic [DATA_W-1:0] pad;

  assign pop_o = !q_empty_i && (!out_valid_q || res_o.ready);

  always_comb begin
    cur_addr  = {1'b0, base_i} + {1'b0, cursor_q};
    // Distance up to the next aligned address.
    pad       = (DATA_W'(0) - cur_addr[DATA_W-1:0]) & cmd_i.arg_b;
    total     = {1'b0, pad} + {1'b0, cmd_i.arg_a};
    with_pad  = {1'b0, cursor_q} + {1'b0, pad};
    final_off = {1'b0, cursor_q} + {1'b0, total[DATA_W-1:0]};

    cursor_d = cursor_q;
    peak_d   = peak_q;
    gen_d    = gen_q;
    status_d = ST_INVALID;
    addr_d   = '0;

    case (cmd_i.op)
      OP_ALLOC: begin
        if (cmd_i.bad_arg) begin
          status_d = ST_INVALID;
        end else if ((cursor_q > cap_i) || ((base_i == '0) && (cap_i != '0))) begin
          status_d = ST_INTERNAL;
        end else if (base_i == '0) begin
          status_d = ST_NOMEM;
        end else if (cmd_i.align_wide) begin
          status_d = ST_INVALID;
        end else if ((cur_addr >> ADDR_CLIP) != '0) begin
          status_d = ST_INTERNAL;
        end else if (total[DATA_W] || with_pad[DATA_W] || final_off[DATA_W]) begin
          status_d = ST_OVERFLOW;
        end else if (final_off[DATA_W-1:0] > cap_i) begin
          status_d = ST_NOMEM;
        end else begin
          status_d = ST_OK;
          addr_d   = base_i + with_pad[DATA_W-1:0];
          cursor_d = final_off[DATA_W-1:0];
          if (peak_q < final_off[DATA_W-1:0]) begin
            peak_d = final_off[DATA_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        // The generation skips zero when it wraps.
        gen_d    = (gen_q == '1) ? DATA_W'(1) : gen_q + 1'b1;
        cursor_d = '0;
        status_d = ST_OK;
      end
      OP_REWIND: begin
        if (cmd_i.arg_b != gen_q) begin
          status_d = ST_INVALID;
        end else if ((cmd_i.arg_a > cursor_q) || (cmd_i.arg_a > cap_i)) begin
          status_d = ST_RANGE;
        end else begin
          cursor_d = cmd_i.arg_a;
          status_d = ST_OK;
        end
      end
      default: begin
        status_d = ST_INVALID;
      end
    endcase

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      peak_q      <= '0;
      gen_q       <= DATA_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        cursor_q <= cursor_d;
        peak_q   <= peak_d;
        gen_q    <= gen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q   <= status_d;
      addr_q     <= addr_d;
      used_q     <= cursor_d;
      peak_out_q <= peak_d;
      epoch_q    <= gen_d;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.data.status        = status_q;
  assign res_o.data.alloc_address = addr_q;
  assign res_o.data.used          = used_q;
  // The user must not change capacity while a result is pending (not enforced).
  assign res_o.data.remaining     = (used_q > cap_i) ? '0 : cap_i - used_q;
  assign res_o.data.peak_used     = peak_out_q;
  assign res_o.data.epoch         = epoch_q;

endmodule

/* rtl/bump_arena_allocator_unit.sv */
// Bump-pointer arena allocator: top level with configuration registers.
// Depends on bal_pkg, bal_stream_if, bal_front, bal_fifo and bal_back.
//
// Usage: program the buffer start address (index 0) and capacity (index 1)
// through the write port while the block is idle. Requests arrive on req_i:
// allocate, full reset or reset to a mark. Each request yields exactly one
// result on res_o with its status, the allocated address and the used,
// remaining, peak and epoch values, so any result may later serve as a mark.
// A request accepted on req_i is written into the two-entry command queue,
// then taken by the execute stage, whose output register holds the result.
// Throughput is one item per cycle while the receiver does not stall, set by
// the update of the cursor register in the back part.
// When the receiver stalls, the result waits in the output register and the
// queue absorbs up to two more requests before req_i.ready drops.
// Reset clears cursor and peak to zero, sets the epoch to one, clears both
// configuration registers and empties the queue and the output register.
module bump_arena_allocator_unit import bal_pkg::*; #(
  parameter int ADDR_W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  bal_stream_if.sink           req_i,
  bal_stream_if.source         res_o
);

  // The command queue decouples classification from execution.
  localparam int QUEUE_DEPTH = 2;

  logic [DATA_W-1:0] base_q, cap_q;
  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              front_cmd, back_cmd;

  // Configuration registers; a write touches only the addressed register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE: base_q <= cfg_wdata_i;
        REG_CAP:  cap_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front part: argument checks that need no arena state.
  bal_front #(
    .ADDR_W (ADDR_W)
  ) u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (front_cmd)
  );

  bal_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .T     (cmd_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (back_cmd),
    .empty_o (q_empty)
  );

  // Back part: all checks and updates that read the cursor or generation.
  bal_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .base_i    (base_q),
    .cap_i     (cap_q),
    .q_empty_i (q_empty),
    .cmd_i     (back_cmd),
    .pop_o     (q_pop),
    .res_o     (res_o)
  );

  // The generation is never zero in any reported result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.data.epoch != '0))
    else $error("result carries a zero epoch");

  // The cursor can only fall below its high-water mark, never rise above it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.data.peak_used >= res_o.data.used))
    else $error("used exceeds peak_used");

  // The back part never takes a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

endmodule
